// ----- rtl/blist_pkg.sv -----
`default_nettype none

package blist_pkg;

  localparam logic [2:0] KIND_INS_HEAD  = 3'd0;
  localparam logic [2:0] KIND_INS_TAIL  = 3'd1;
  localparam logic [2:0] KIND_INS_AFTER = 3'd2;
  localparam logic [2:0] KIND_DEL_HEAD  = 3'd3;
  localparam logic [2:0] KIND_DEL_TAIL  = 3'd4;
  localparam logic [2:0] KIND_DEL_AFTER = 3'd5;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_EMPTY   = 2'd2;
  localparam logic [1:0] ST_MISSING = 2'd3;

  // per-cycle command broadcast to every cell, already gated by commit and status
  typedef struct packed {
    logic ins_head;
    logic ins_tail;
    logic ins_after;
    logic del_head;
    logic del_after;
  } cell_cmd_t;

endpackage

`default_nettype wire

// ----- rtl/blist_cell.sv -----
`default_nettype none

module blist_cell import blist_pkg::*; #(
  parameter int DEPTH = 4,
  parameter int IDX   = 0,
  localparam int CW   = $clog2(DEPTH + 1)
) (
  input  wire logic          clk,
  input  wire cell_cmd_t     cmd,
  input  wire logic [CW-1:0] entry_count,
  input  wire logic [31:0]   value,
  input  wire logic [31:0]   target,
  input  wire logic [31:0]   left_word,
  input  wire logic [31:0]   right_word,
  input  wire logic          fb_in,
  input  wire logic          fb_left,
  output logic [31:0]        word,
  output logic               fb_out,
  output logic               succ
);

  localparam logic [CW-1:0] IDX_C = CW'(IDX);

  logic        valid;
  logic        match;
  logic [31:0] word_next;

  assign valid  = IDX_C < entry_count;
  assign match  = valid && (word == target);
  // fb_in: a match exists in some cell closer to the head
  assign fb_out = fb_in | match;
  assign succ   = valid & fb_in;

  always_comb begin
    word_next = word;
    if (cmd.ins_head) begin
      word_next = left_word;
    end else if (cmd.ins_tail) begin
      if (IDX_C == entry_count) word_next = value;
    end else if (cmd.ins_after) begin
      // first match sits at least two places toward the head: shift,
      // first match is the left neighbor: load the new word
      if (fb_left) word_next = left_word;
      else if (fb_in) word_next = value;
    end else if (cmd.del_head) begin
      word_next = right_word;
    end else if (cmd.del_after) begin
      if (fb_in) word_next = right_word;
    end
  end

  always_ff @(posedge clk) begin
    word <= word_next;
  end

endmodule

`default_nettype wire

// ----- rtl/bounded_ordered_list_top.sv -----
//  channel | signals                          | direction
//  --------+----------------------------------+----------
//  in      | in_valid in_ready kind value target | in
//  out     | out_valid out_ready status count | out
//
//  each transaction is captured in S_IDLE and then executed in S_EXEC, where the row of
//  cells searches for the target along its match chain and shifts in one step
//  a result waits in the output register; the next transaction is captured
//  meanwhile and commits once that register is free
//  rst clears the entry count, the state and out_valid; stored words are not cleared

`default_nettype none

module bounded_ordered_list_top import blist_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  kind,
  input  wire logic [31:0] value,
  input  wire logic [31:0] target,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       status,
  output logic [2:0]       count
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t        state, state_next;
  logic [2:0]    kind_q;
  logic [31:0]   value_q;
  logic [31:0]   target_q;
  logic [CW-1:0] entry_count, entry_count_next;
  logic [1:0]    status_next;
  logic          accept;
  logic          commit;
  logic          op_ok;
  logic          full;
  logic          found;
  logic          found_succ;
  logic [31:0]   count_ext;
  cell_cmd_t     cmd;

  logic [31:0]  words [DEPTH];
  logic [DEPTH:0] fb;
  logic [DEPTH-1:0] succ;

  assign in_ready = state == S_IDLE;
  assign accept   = in_valid && in_ready;
  assign commit   = (state == S_EXEC) && (!out_valid || out_ready);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (accept) state_next = S_EXEC;
      S_EXEC: if (commit) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_q   <= kind;
      value_q  <= value;
      target_q <= target;
    end
  end

  // match chain through the row of cells
  assign fb[0] = 1'b0;

  generate
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      blist_cell #(
        .DEPTH(DEPTH),
        .IDX  (i)
      ) u_cell (
        .clk        (clk),
        .cmd        (cmd),
        .entry_count(entry_count),
        .value      (value_q),
        .target     (target_q),
        .left_word  ((i == 0) ? value_q : words[(i == 0) ? 0 : i - 1]),
        .right_word ((i == DEPTH - 1) ? words[i] : words[(i == DEPTH - 1) ? i : i + 1]),
        .fb_in      (fb[i]),
        .fb_left    ((i == 0) ? 1'b0 : fb[(i == 0) ? 0 : i - 1]),
        .word       (words[i]),
        .fb_out     (fb[i+1]),
        .succ       (succ[i])
      );
    end
  endgenerate

  assign full       = entry_count >= DEPTH_C;
  assign found      = fb[DEPTH];
  assign found_succ = |succ;

  always_comb begin
    status_next = ST_OK;
    unique case (kind_q) inside
      KIND_INS_HEAD, KIND_INS_TAIL: if (full) status_next = ST_FULL;
      KIND_INS_AFTER: begin
        if (full) status_next = ST_FULL;
        else if (!found) status_next = ST_MISSING;
      end
      KIND_DEL_HEAD, KIND_DEL_TAIL: if (entry_count == '0) status_next = ST_EMPTY;
      KIND_DEL_AFTER: if (!found_succ) status_next = ST_MISSING;
      default: status_next = ST_OK;
    endcase
  end

  assign op_ok = commit && (status_next == ST_OK);

  always_comb begin
    cmd.ins_head  = op_ok && (kind_q == KIND_INS_HEAD);
    cmd.ins_tail  = op_ok && (kind_q == KIND_INS_TAIL);
    cmd.ins_after = op_ok && (kind_q == KIND_INS_AFTER);
    cmd.del_head  = op_ok && (kind_q == KIND_DEL_HEAD);
    cmd.del_after = op_ok && (kind_q == KIND_DEL_AFTER);
  end

  always_comb begin
    entry_count_next = entry_count;
    if (op_ok) begin
      if (kind_q == KIND_INS_HEAD || kind_q == KIND_INS_TAIL || kind_q == KIND_INS_AFTER) begin
        entry_count_next = entry_count + CW'(1);
      end else if (kind_q == KIND_DEL_HEAD || kind_q == KIND_DEL_TAIL ||
                   kind_q == KIND_DEL_AFTER) begin
        entry_count_next = entry_count - CW'(1);
      end
    end
  end

  assign count_ext = 32'(entry_count_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
      out_valid   <= 1'b0;
    end else begin
      entry_count <= entry_count_next;
      if (commit) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      status <= status_next;
      count  <= count_ext[2:0];
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= DEPTH_C)
    else $error("entry count above depth");

  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == S_EXEC)
    else $error("accepted transaction not executing");

  a_commit_out: assert property (@(posedge clk) disable iff (rst)
    commit |=> out_valid)
    else $error("commit without result");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    !commit |=> entry_count == $past(entry_count))
    else $error("entry count changed without commit");

endmodule

`default_nettype wire
